@@ hw/rtl/lsr_pkg.sv @@
`timescale 1ns / 1ps

package lsr_pkg;

  localparam int SLOTS    = 16;
  localparam int SLOT_W   = 4;
  localparam int LINK_W   = 5;
  localparam int COUNT_W  = 5;
  localparam int VALUE_W  = 32;

  localparam logic [LINK_W-1:0]  SENTINEL = LINK_W'(SLOTS);
  localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(SLOTS);

  typedef logic [1:0] req_t;
  typedef logic [1:0] status_t;

  localparam req_t REQ_PUSH = 2'd0;
  localparam req_t REQ_POP  = 2'd1;
  localparam req_t REQ_DEL  = 2'd2;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_EMPTY    = 2'd1;
  localparam status_t ST_BUSY     = 2'd2;
  localparam status_t ST_UNLINKED = 2'd3;

endpackage

@@ hw/rtl/linked_stack_with_removal_unit.sv @@
`timescale 1ns / 1ps

// Stack of 16 slots kept as a doubly linked list with a bottom sentinel.
// Input channel (in_valid / in_stall): one request per accepted item, with
// in_req_type (push, pop, delete named slot), in_slot and in_value.
// Result channel (out_valid / out_stall): exactly one result per request,
// in order: out_popped_value (zero unless a pop succeeds), out_status
// (ok, empty, full or busy, not linked) and out_depth after the request.
// A request is captured in an input register, its link, value and in-use
// updates are worked out in one pass of short logic over the flop-based link
// tables, and the result lands in an output register. One request is
// accepted every cycle while the receiver does not stall; the link tables
// are read at one address each per cycle.
// While the receiver stalls, the result is held, the captured request waits
// behind it, and in_stall rises once both registers are full.
// Synchronous reset (rst_n low) empties the stack: no slot in use, depth
// zero, top at the sentinel; link and value tables are not cleared.
module linked_stack_with_removal_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_req_type,
  input  logic [lsr_pkg::SLOT_W-1:0]   in_slot,
  input  logic [lsr_pkg::VALUE_W-1:0]  in_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lsr_pkg::VALUE_W-1:0]  out_popped_value,
  output logic [1:0]                   out_status,
  output logic [lsr_pkg::COUNT_W-1:0]  out_depth
);

  localparam int SLOTS   = lsr_pkg::SLOTS;
  localparam int SLOT_W  = lsr_pkg::SLOT_W;
  localparam int LINK_W  = lsr_pkg::LINK_W;
  localparam int COUNT_W = lsr_pkg::COUNT_W;
  localparam int VALUE_W = lsr_pkg::VALUE_W;

  // stack state
  logic [LINK_W-1:0]  next_link_r [0:SLOTS];
  logic [LINK_W-1:0]  prev_link_r [0:SLOTS];
  logic [VALUE_W-1:0] slot_value_r [0:SLOTS-1];
  logic [SLOTS-1:0]   in_use_r;
  logic [LINK_W-1:0]  top_r, top_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  // captured request
  logic                  req_valid_r;
  lsr_pkg::req_t         req_type_r;
  logic [SLOT_W-1:0]     req_slot_r;
  logic [VALUE_W-1:0]    req_value_r;

  // result register
  logic                  out_valid_r;
  logic [VALUE_W-1:0]    out_popped_r, popped_nxt;
  lsr_pkg::status_t      out_status_r, status_nxt;
  logic [COUNT_W-1:0]    out_depth_r;

  logic advance;
  logic take_in;

  // table access for the request in flight
  logic [LINK_W-1:0]  slot_link;
  logic [LINK_W-1:0]  prev_raddr;
  logic [LINK_W-1:0]  prev_rd;
  logic [LINK_W-1:0]  next_rd;
  logic               nl_we0, nl_we1, pl_we, val_we, use_set, use_clr;
  logic [LINK_W-1:0]  nl_wa0, nl_wd0, nl_wa1, nl_wd1, pl_wa, pl_wd;
  logic [SLOT_W-1:0]  use_clr_addr;

  assign advance  = req_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = req_valid_r && !advance;
  assign take_in  = in_valid && !in_stall;

  assign slot_link  = {1'b0, req_slot_r};
  assign prev_raddr = (req_type_r == lsr_pkg::REQ_POP) ? top_r : slot_link;
  assign prev_rd    = prev_link_r[prev_raddr];
  assign next_rd    = next_link_r[slot_link];

  always_comb begin
    status_nxt   = lsr_pkg::ST_OK;
    popped_nxt   = '0;
    top_nxt      = top_r;
    count_nxt    = count_r;
    nl_we0       = 1'b0;
    nl_wa0       = top_r;
    nl_wd0       = slot_link;
    nl_we1       = 1'b0;
    nl_wa1       = slot_link;
    nl_wd1       = lsr_pkg::SENTINEL;
    pl_we        = 1'b0;
    pl_wa        = slot_link;
    pl_wd        = top_r;
    val_we       = 1'b0;
    use_set      = 1'b0;
    use_clr      = 1'b0;
    use_clr_addr = req_slot_r;
    case (req_type_r)
      lsr_pkg::REQ_PUSH: begin
        if (in_use_r[req_slot_r] || count_r >= lsr_pkg::FULL_CNT) begin
          status_nxt = lsr_pkg::ST_BUSY;
        end else begin
          // link above the old top, sentinel above the new one
          nl_we0    = 1'b1;
          nl_we1    = 1'b1;
          pl_we     = 1'b1;
          val_we    = 1'b1;
          use_set   = 1'b1;
          top_nxt   = slot_link;
          count_nxt = count_r + 1'b1;
        end
      end
      lsr_pkg::REQ_POP: begin
        if (count_r == '0 || top_r >= lsr_pkg::SENTINEL) begin
          status_nxt = lsr_pkg::ST_EMPTY;
        end else begin
          popped_nxt   = slot_value_r[top_r[SLOT_W-1:0]];
          nl_we0       = 1'b1;
          nl_wa0       = prev_rd;
          nl_wd0       = lsr_pkg::SENTINEL;
          top_nxt      = prev_rd;
          use_clr      = 1'b1;
          use_clr_addr = top_r[SLOT_W-1:0];
          count_nxt    = count_r - 1'b1;
        end
      end
      lsr_pkg::REQ_DEL: begin
        if (count_r == '0) begin
          status_nxt = lsr_pkg::ST_EMPTY;
        end else if (!in_use_r[req_slot_r]) begin
          status_nxt = lsr_pkg::ST_UNLINKED;
        end else begin
          // bridge the neighbors around the slot
          nl_we0    = 1'b1;
          nl_wa0    = prev_rd;
          nl_wd0    = next_rd;
          pl_we     = 1'b1;
          pl_wa     = next_rd;
          pl_wd     = prev_rd;
          use_clr   = 1'b1;
          if (top_r == slot_link) begin
            top_nxt = prev_rd;
          end
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
        status_nxt = lsr_pkg::ST_OK;
      end
    endcase
  end

  // link and value tables: no reset, only linked entries are ever read
  always_ff @(posedge clk) begin
    if (advance) begin
      if (nl_we0) begin
        next_link_r[nl_wa0] <= nl_wd0;
      end
      if (nl_we1) begin
        next_link_r[nl_wa1] <= nl_wd1;
      end
      if (pl_we) begin
        prev_link_r[pl_wa] <= pl_wd;
      end
      if (val_we) begin
        slot_value_r[req_slot_r] <= req_value_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
      top_r    <= lsr_pkg::SENTINEL;
      count_r  <= '0;
    end else if (advance) begin
      if (use_set) begin
        in_use_r[req_slot_r] <= 1'b1;
      end
      if (use_clr) begin
        in_use_r[use_clr_addr] <= 1'b0;
      end
      top_r   <= top_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (take_in) begin
      req_valid_r <= 1'b1;
    end else if (advance) begin
      req_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      req_type_r  <= in_req_type;
      req_slot_r  <= in_slot;
      req_value_r <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_popped_r <= popped_nxt;
      out_status_r <= status_nxt;
      out_depth_r  <= count_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_popped_r;
  assign out_status       = out_status_r;
  assign out_depth        = out_depth_r;

endmodule
